[rtl/core/scs_pkg.sv]
// Shared constants and types of the strip cross-talk smoother.
// Used by the channel interfaces, the weighting unit and the top level.
package scs_pkg;

   localparam int CHARGE_BITS_DEF     = 24;
   localparam int COEFF_FRAC_BITS_DEF = 16;
   localparam int CSR_BITS            = 16;

   typedef enum logic [1:0] {
      MODE_PASS,
      MODE_EDGE,
      MODE_INNER
   } weight_mode_type;

endpackage

[rtl/core/scs_req_if.sv]
// Request channel of the strip cross-talk smoother: valid/ready plus strip charge.
// Depends on scs_pkg for the default charge width.
interface scs_req_if import scs_pkg::*; #(
   parameter int CHARGE_BITS = CHARGE_BITS_DEF
) ();
   logic                   valid;
   logic                   ready;
   logic [CHARGE_BITS-1:0] charge_in;
   logic                   side_last;

   modport source (output valid, output charge_in, output side_last, input ready);
   modport sink   (input valid, input charge_in, input side_last, output ready);
endinterface

[rtl/core/scs_rsp_if.sv]
// Result channel of the strip cross-talk smoother: valid/ready plus smoothed charge.
// Depends on scs_pkg for the default charge width.
interface scs_rsp_if import scs_pkg::*; #(
   parameter int CHARGE_BITS = CHARGE_BITS_DEF
) ();
   logic                   valid;
   logic                   ready;
   logic [CHARGE_BITS-1:0] charge_out;
   logic                   strip_last;

   modport source (output valid, output charge_out, output strip_last, input ready);
   modport sink   (input valid, input charge_out, input strip_last, output ready);
endinterface

[rtl/core/scs_weight_unit.sv]
// Weighting datapath: own*1 + c*(neighbor sum - k*own), rounded to nearest.
// One signed multiplier; depends on scs_pkg for the mode type.
module scs_weight_unit import scs_pkg::*; #(
   parameter int CHARGE_BITS     = CHARGE_BITS_DEF,
   parameter int COEFF_FRAC_BITS = COEFF_FRAC_BITS_DEF
) (
   input  weight_mode_type        mode,
   input  logic [CSR_BITS-1:0]    coeff,
   input  logic [CHARGE_BITS-1:0] left,
   input  logic [CHARGE_BITS-1:0] own,
   input  logic [CHARGE_BITS-1:0] right,
   output logic [CHARGE_BITS-1:0] result
);
   localparam int DW = CHARGE_BITS + 2;
   localparam int CW = (COEFF_FRAC_BITS > CSR_BITS) ? COEFF_FRAC_BITS : CSR_BITS;
   localparam int AW = CHARGE_BITS + COEFF_FRAC_BITS + 3;

   logic [CW-1:0]               coeff_ext;
   logic [CW-1:0]               half_ext;
   logic [CW-1:0]               coeff_lim;
   logic signed [COEFF_FRAC_BITS:0] coeff_s;
   logic signed [DW-1:0]        own_s;
   logic signed [DW-1:0]        left_s;
   logic signed [DW-1:0]        right_s;
   logic signed [DW-1:0]        diff;
   logic signed [AW-1:0]        prod;
   logic signed [AW-1:0]        acc;

   assign coeff_ext = CW'(coeff);
   assign half_ext  = CW'(1) << (COEFF_FRAC_BITS - 1);
   assign coeff_lim = (coeff_ext > half_ext) ? half_ext : coeff_ext;
   assign coeff_s   = $signed({1'b0, coeff_lim[COEFF_FRAC_BITS-1:0]});

   assign own_s   = $signed({2'b00, own});
   assign left_s  = $signed({2'b00, left});
   assign right_s = $signed({2'b00, right});

   always_comb begin
      case (mode)
         MODE_EDGE:  diff = right_s - own_s;
         MODE_INNER: diff = left_s + right_s - (own_s <<< 1);
         default:    diff = '0;
      endcase
   end

   assign prod = AW'(coeff_s) * AW'(diff);
   assign acc  = $signed(AW'(own) << COEFF_FRAC_BITS) + prod
               + $signed(AW'(half_ext));

   assign result = (mode == MODE_PASS) ? own
                 : acc[COEFF_FRAC_BITS + CHARGE_BITS - 1 : COEFF_FRAC_BITS];
endmodule

[rtl/core/strip_crosstalk_smoother.sv]
// Strip cross-talk smoother: three-tap symmetric filter with clamped edges.
// Channels: req (sink) takes one strip charge with side_last, rsp (source)
//    returns smoothed charges with strip_last; csr_wr_en/csr_wr_data load c.
// A request is first held in an input register; the weighting unit then computes
//    each result into the rsp register, which presents it. Results lag by one strip.
// Throughput is one request per cycle while rsp.ready is high, except that the last
//    strip of a side with more than one strip yields two results in turn from
//    the shared weighting unit and holds off the next request until both are out;
//    the first strip of a side yields none.
// A one-strip side passes through unchanged with strip_last set.
// When rsp.ready is low the rsp register holds its result and the input
//    register holds its request; req.ready drops once both are full.
// Reset empties both registers, forgets held strips and clears c to zero.
// Depends on scs_pkg, scs_req_if, scs_rsp_if and scs_weight_unit.
module strip_crosstalk_smoother import scs_pkg::*; #(
   parameter int CHARGE_BITS     = CHARGE_BITS_DEF,
   parameter int COEFF_FRAC_BITS = COEFF_FRAC_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   scs_req_if.sink             req,
   scs_rsp_if.source           rsp,
   input  logic                csr_wr_en,
   input  logic [CSR_BITS-1:0] csr_wr_data
);
   typedef enum logic [1:0] {
      FILL_EMPTY,
      FILL_FIRST,
      FILL_INNER
   } fill_type;

   logic                   in_valid_ff, in_valid_in;
   logic [CHARGE_BITS-1:0] in_charge_ff, in_charge_in;
   logic                   in_last_ff, in_last_in;
   logic [CSR_BITS-1:0]    coeff_ff, coeff_in;
   logic [CHARGE_BITS-1:0] left_ff, left_in;
   logic [CHARGE_BITS-1:0] held_ff, held_in;
   fill_type               fill_ff, fill_in;
   logic                   phase_ff, phase_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [CHARGE_BITS-1:0] rsp_charge_ff, rsp_charge_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic                   out_free;
   logic                   needs_out;
   logic                   proc;
   logic                   item_done;
   logic                   req_take;
   weight_mode_type        mode;
   logic [CHARGE_BITS-1:0] op_left;
   logic [CHARGE_BITS-1:0] op_own;
   logic [CHARGE_BITS-1:0] op_right;
   logic                   op_last;
   logic [CHARGE_BITS-1:0] weighted;

   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign needs_out = !(fill_ff == FILL_EMPTY && !in_last_ff);
   assign proc      = in_valid_ff && (!needs_out || out_free);
   assign item_done = proc && (fill_ff == FILL_EMPTY || !in_last_ff || phase_ff);
   assign req.ready = !in_valid_ff || item_done;
   assign req_take  = req.valid && req.ready;

   always_comb begin
      op_left  = left_ff;
      op_own   = held_ff;
      op_right = in_charge_ff;
      op_last  = 1'b0;
      if (fill_ff == FILL_EMPTY) begin
         mode    = MODE_PASS;
         op_own  = in_charge_ff;
         op_last = 1'b1;
      end else if (phase_ff) begin
         mode     = MODE_EDGE;
         op_own   = in_charge_ff;
         op_right = held_ff;
         op_last  = 1'b1;
      end else if (fill_ff == FILL_FIRST) begin
         mode = MODE_EDGE;
      end else begin
         mode = MODE_INNER;
      end
   end

   scs_weight_unit #(
      .CHARGE_BITS     (CHARGE_BITS),
      .COEFF_FRAC_BITS (COEFF_FRAC_BITS)
   ) u_weight (
      .mode   (mode),
      .coeff  (coeff_ff),
      .left   (op_left),
      .own    (op_own),
      .right  (op_right),
      .result (weighted)
   );

   always_comb begin
      in_valid_in   = in_valid_ff;
      in_charge_in  = in_charge_ff;
      in_last_in    = in_last_ff;
      coeff_in      = csr_wr_en ? csr_wr_data : coeff_ff;
      left_in       = left_ff;
      held_in       = held_ff;
      fill_in       = fill_ff;
      phase_in      = phase_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_charge_in = rsp_charge_ff;
      rsp_last_in   = rsp_last_ff;

      if (req_take) begin
         in_valid_in  = 1'b1;
         in_charge_in = req.charge_in;
         in_last_in   = req.side_last;
      end else if (item_done) begin
         in_valid_in = 1'b0;
      end

      if (proc) begin
         if (fill_ff == FILL_EMPTY) begin
            if (!in_last_ff) begin
               held_in = in_charge_ff;
               fill_in = FILL_FIRST;
            end
         end else if (phase_ff) begin
            left_in  = '0;
            held_in  = '0;
            fill_in  = FILL_EMPTY;
            phase_in = 1'b0;
         end else if (in_last_ff) begin
            phase_in = 1'b1;
         end else begin
            left_in = held_ff;
            held_in = in_charge_ff;
            fill_in = FILL_INNER;
         end
      end

      if (proc && needs_out) begin
         rsp_valid_in  = 1'b1;
         rsp_charge_in = weighted;
         rsp_last_in   = op_last;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         coeff_ff     <= '0;
         left_ff      <= '0;
         held_ff      <= '0;
         fill_ff      <= FILL_EMPTY;
         phase_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         coeff_ff     <= coeff_in;
         left_ff      <= left_in;
         held_ff      <= held_in;
         fill_ff      <= fill_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_charge_ff  <= in_charge_in;
      in_last_ff    <= in_last_in;
      rsp_charge_ff <= rsp_charge_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.charge_out = rsp_charge_ff;
   assign rsp.strip_last = rsp_last_ff;
endmodule
